// ----- design/ipmd_pkg.sv -----
// -----------------------------------------------------------------------------
// ipmd_pkg: shared types and constants for the incremental PID motor drive
// Field widths, register indexes and reset values used by the interfaces and
// the top level.
// -----------------------------------------------------------------------------
package ipmd_pkg;

   // payload widths
   localparam int COUNT_W  = 16;   // encoder count, target speed, error
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 16;
   localparam int BTICK_W  = 6;
   localparam int BRAKE_W  = 8;
   localparam int DRIVE_W  = 17;   // drive accumulator, signed
   localparam int DUTY_W   = 16;

   // config port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P       = 3'd0,
      CSR_GAIN_I       = 3'd1,
      CSR_GAIN_D       = 3'd2,
      CSR_OUTPUT_LIMIT = 3'd3,
      CSR_BRAKE_TICKS  = 3'd4
   } csr_index_type;

   // register reset values
   localparam logic [GAIN_W-1:0]  GAIN_P_RESET       = 16'd800;
   localparam logic [GAIN_W-1:0]  GAIN_I_RESET       = 16'd100;
   localparam logic [GAIN_W-1:0]  GAIN_D_RESET       = 16'd0;
   localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RESET = 16'd65535;
   localparam logic [BTICK_W-1:0] BRAKE_TICKS_RESET  = 6'd5;

   // encoder reads this count at standstill
   localparam logic [COUNT_W-1:0] SPEED_OFFSET = 16'd50;
   localparam logic [BRAKE_W-1:0] BRAKE_MAX    = 8'd255;

endpackage

// ----- design/ipmd_if.sv -----
// -----------------------------------------------------------------------------
// ipmd interfaces: request, response and register-write channels
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// -----------------------------------------------------------------------------
interface ipmd_req_if import ipmd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [COUNT_W-1:0]  encoder_count;
   logic signed [COUNT_W-1:0]  target_speed;

   modport source (output valid, output encoder_count, output target_speed, input ready);
   modport sink   (input valid, input encoder_count, input target_speed, output ready);
endinterface

interface ipmd_rsp_if import ipmd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [DRIVE_W-1:0]  drive_value;
   logic                       pin_a;
   logic                       pin_b;
   logic [DUTY_W-1:0]          pwm_duty;
   logic                       braking;

   modport source (output valid, output drive_value, output pin_a, output pin_b,
                   output pwm_duty, output braking, input ready);
   modport sink   (input valid, input drive_value, input pin_a, input pin_b,
                   input pwm_duty, input braking, output ready);
endinterface

interface ipmd_csr_if import ipmd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/incremental_pid_motor_drive.sv -----
// A request word passes the stage-1, product and response registers before
// its response is valid. Throughput: one word per cycle; the three-stage pipe
// (error/brake, multiply, accumulate) has no cross-stage feedback; only rsp stalls it.
// Reset (synchronous, active high) clears the error history, accumulator,
// brake counter and pipe valids, and loads the register defaults.
// -----------------------------------------------------------------------------
// incremental_pid_motor_drive: incremental PID speed loop with H-bridge output
// Per tick: error from encoder count and target, incremental PID term, clamped
// drive accumulator, brake-on-reversal counter, bridge pins and PWM duty.
// -----------------------------------------------------------------------------
module incremental_pid_motor_drive import ipmd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ipmd_req_if.sink    req_chan,
   ipmd_rsp_if.source  rsp_chan,
   ipmd_csr_if.sink    csr_chan
);

   localparam int D1_W  = COUNT_W + 1;          // e - e1
   localparam int D2_W  = COUNT_W + 2;          // e - 2*e1 + e2
   localparam int GX_W  = GAIN_W + 1;           // gain as signed operand
   localparam int PP_W  = GX_W + D1_W;
   localparam int PI_W  = GX_W + COUNT_W;
   localparam int PD_W  = GX_W + D2_W;
   localparam int SUM_W = PD_W + 1;
   localparam int ACC_W = DRIVE_W + 1;

   // ---------------------------------------------------------------- registers
   logic [GAIN_W-1:0]   gain_p_ff, gain_i_ff, gain_d_ff;
   logic [LIMIT_W-1:0]  output_limit_ff;
   logic [BTICK_W-1:0]  brake_ticks_ff;

   // config writes land at once; the host must write only while the pipe is empty (not enforced here)
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff       <= GAIN_P_RESET;
         gain_i_ff       <= GAIN_I_RESET;
         gain_d_ff       <= GAIN_D_RESET;
         output_limit_ff <= OUTPUT_LIMIT_RESET;
         brake_ticks_ff  <= BRAKE_TICKS_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_GAIN_P:       gain_p_ff       <= csr_chan.data[GAIN_W-1:0];
            CSR_GAIN_I:       gain_i_ff       <= csr_chan.data[GAIN_W-1:0];
            CSR_GAIN_D:       gain_d_ff       <= csr_chan.data[GAIN_W-1:0];
            CSR_OUTPUT_LIMIT: output_limit_ff <= csr_chan.data[LIMIT_W-1:0];
            CSR_BRAKE_TICKS:  brake_ticks_ff  <= csr_chan.data[BTICK_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // Each stage moves when the one after it is empty or moving, so bubbles
   // collapse and a waiting response does not block upstream stages.
   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic out_free, s2_free, s1_free, req_take;

   assign out_free = ~out_valid_ff | rsp_chan.ready;
   assign s2_free  = ~s2_valid_ff | out_free;
   assign s1_free  = ~s1_valid_ff | s2_free;
   assign req_chan.ready = s1_free;
   assign req_take = req_chan.valid & s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free)  s1_valid_ff  <= req_chan.valid;
         if (s2_free)  s2_valid_ff  <= s1_valid_ff;
         if (out_free) out_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // Error and its differences, plus the brake counter. Both depend only on
   // the request sequence, so their history updates as each word is taken.
   logic signed [COUNT_W-1:0] error_last_ff, error_prev_ff, target_last_ff;
   logic [BRAKE_W-1:0]        brake_count_ff;

   logic signed [COUNT_W-1:0] err_in;
   logic signed [D1_W-1:0]    d1_in;
   logic signed [D2_W-1:0]    d2_in;
   logic                      reversal;
   logic [BRAKE_W:0]          brake_sum;
   logic [BRAKE_W-1:0]        brake_armed, brake_count_in;

   // speed = count - 50; error = target - speed, all modulo 2^16
   assign err_in = req_chan.target_speed - req_chan.encoder_count + $signed(SPEED_OFFSET);
   assign d1_in  = D1_W'(err_in) - D1_W'(error_last_ff);
   assign d2_in  = D2_W'(err_in) - (D2_W'(error_last_ff) <<< 1) + D2_W'(error_prev_ff);

   // reversal: both targets nonzero with opposite signs
   assign reversal = (req_chan.target_speed > 0 && target_last_ff < 0) ||
                     (req_chan.target_speed < 0 && target_last_ff > 0);
   assign brake_sum = {1'b0, brake_count_ff} + (BRAKE_W+1)'(brake_ticks_ff);

   always_comb begin
      brake_armed = brake_count_ff;
      if (reversal) begin
         brake_armed = (brake_sum > (BRAKE_W+1)'(BRAKE_MAX)) ? BRAKE_MAX
                                                           : brake_sum[BRAKE_W-1:0];
      end
      brake_count_in = (brake_armed != '0) ? brake_armed - 1'b1 : brake_armed;
   end

   logic signed [COUNT_W-1:0] s1_err_ff;
   logic signed [D1_W-1:0]    s1_d1_ff;
   logic signed [D2_W-1:0]    s1_d2_ff;
   logic                      s1_brake_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_last_ff  <= '0;
         error_prev_ff  <= '0;
         target_last_ff <= '0;
         brake_count_ff <= '0;
      end else if (req_take) begin
         error_last_ff  <= err_in;
         error_prev_ff  <= error_last_ff;
         target_last_ff <= req_chan.target_speed;
         brake_count_ff <= brake_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_err_ff   <= err_in;
         s1_d1_ff    <= d1_in;
         s1_d2_ff    <= d2_in;
         s1_brake_ff <= (brake_count_in != '0);
      end
   end

   // ---------------------------------------------------------------- stage 2
   // Three products (17x17, 17x16 and 17x18 bits), registered before the sum.
   logic signed [PP_W-1:0] prod_p_in, prod_p_ff;
   logic signed [PI_W-1:0] prod_i_in, prod_i_ff;
   logic signed [PD_W-1:0] prod_d_in, prod_d_ff;
   logic                   s2_brake_ff;

   assign prod_p_in = $signed({1'b0, gain_p_ff}) * s1_d1_ff;
   assign prod_i_in = $signed({1'b0, gain_i_ff}) * s1_err_ff;
   assign prod_d_in = $signed({1'b0, gain_d_ff}) * s1_d2_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_free) begin
         prod_p_ff   <= prod_p_in;
         prod_i_ff   <= prod_i_in;
         prod_d_ff   <= prod_d_in;
         s2_brake_ff <= s1_brake_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // Sum, saturate to int16, accumulate, clamp to +/- limit, drive the bridge.
   logic signed [SUM_W-1:0]   term_sum;
   logic signed [COUNT_W-1:0] term_sat;
   logic signed [ACC_W-1:0]   acc_sum, acc_lim, acc_clamp;
   logic signed [DRIVE_W-1:0] drive_accum_ff, drive_in, drive_neg;
   logic                      acc_update;

   assign term_sum = SUM_W'(prod_p_ff) + SUM_W'(prod_i_ff) + SUM_W'(prod_d_ff);

   always_comb begin
      if (term_sum > 36'sd32767)
         term_sat = 16'sh7FFF;
      else if (term_sum < -36'sd32768)
         term_sat = 16'sh8000;
      else
         term_sat = term_sum[COUNT_W-1:0];
   end

   assign acc_sum = ACC_W'(drive_accum_ff) + ACC_W'(term_sat);
   assign acc_lim = $signed({{(ACC_W-LIMIT_W){1'b0}}, output_limit_ff});

   always_comb begin
      if (acc_sum > acc_lim)
         acc_clamp = acc_lim;
      else if (acc_sum < -acc_lim)
         acc_clamp = -acc_lim;
      else
         acc_clamp = acc_sum;
   end

   assign drive_in   = acc_clamp[DRIVE_W-1:0];
   assign drive_neg  = -drive_in;
   assign acc_update = s2_valid_ff & out_free;

   always_ff @(posedge clock) begin
      if (reset)
         drive_accum_ff <= '0;
      else if (acc_update)
         drive_accum_ff <= drive_in;
   end

   // response register
   logic [DUTY_W-1:0] duty_in;
   logic              pin_a_in, pin_b_in;
   logic              pin_a_ff, pin_b_ff, braking_ff;
   logic [DUTY_W-1:0] pwm_duty_ff;

   always_comb begin
      if (s2_brake_ff) begin
         // brake: both low-side paths on, no PWM
         pin_a_in = 1'b1;
         pin_b_in = 1'b1;
         duty_in  = '0;
      end else if (drive_in > 0) begin
         pin_a_in = 1'b0;
         pin_b_in = 1'b1;
         duty_in  = drive_in[DUTY_W-1:0];
      end else begin
         // zero drive falls here: reverse pins, duty 0
         pin_a_in = 1'b1;
         pin_b_in = 1'b0;
         duty_in  = drive_neg[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (acc_update) begin
         pin_a_ff    <= pin_a_in;
         pin_b_ff    <= pin_b_in;
         pwm_duty_ff <= duty_in;
         braking_ff  <= s2_brake_ff;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.drive_value = drive_accum_ff;
   assign rsp_chan.pin_a       = pin_a_ff;
   assign rsp_chan.pin_b       = pin_b_ff;
   assign rsp_chan.pwm_duty    = pwm_duty_ff;
   assign rsp_chan.braking     = braking_ff;

   // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
   // freshly updated accumulator never exceeds the clamp
   a_acc_in_limit: assert property (@(posedge clock) disable iff (reset)
      acc_update |=> (ACC_W'(drive_accum_ff) <= acc_lim) &&
                     (ACC_W'(drive_accum_ff) >= -acc_lim))
      else $error("drive accumulator outside output limit");

   // request side only backs up when every stage is occupied
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && s2_valid_ff && out_valid_ff)
      else $error("request stalled with an empty stage");

   // error history and brake counter move only with an accepted word
   a_hist_hold: assert property (@(posedge clock) disable iff (reset)
      !req_take |=> $stable(brake_count_ff) && $stable(error_last_ff) &&
                    $stable(target_last_ff))
      else $error("history changed without a request word");

   // a response word appears only behind a valid multiply stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s2_valid_ff))
      else $error("response valid without an upstream word");
`endif

endmodule

// ----- tb/sv/incremental_pid_motor_drive_tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// incremental_pid_motor_drive_tb: self-checking bench for the PID motor drive
// Feeds encoder/target ticks through the request channel and predicts every
// response word (drive, bridge pins, duty, brake flag) with a cycle-free model
// kept in step with the register writes. Both handshake sides stall in bursts.
// -----------------------------------------------------------------------------
module incremental_pid_motor_drive_tb;
   import ipmd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;   // cycles without any handshake
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_TICKS    = 185;

   typedef struct {
      logic signed [COUNT_W-1:0] encoder_count;
      logic signed [COUNT_W-1:0] target_speed;
   } tick_word_type;

   typedef struct {
      logic signed [DRIVE_W-1:0] drive_value;
      logic                      pin_a;
      logic                      pin_b;
      logic [DUTY_W-1:0]         pwm_duty;
      logic                      braking;
   } bridge_word_type;

   logic clock;
   logic reset;

   ipmd_req_if req_chan ();
   ipmd_rsp_if rsp_chan ();
   ipmd_csr_if csr_chan ();

   incremental_pid_motor_drive u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // shadow copy of the register file, updated on each accepted csr word
   logic [GAIN_W-1:0]          kp_q;
   logic [GAIN_W-1:0]          ki_q;
   logic [GAIN_W-1:0]          kd_q;
   logic [LIMIT_W-1:0]         limit_q;
   logic [BTICK_W-1:0]         brake_ticks_q;

   // loop state mirrored from the block
   logic signed [COUNT_W-1:0]  err_last_q;
   logic signed [COUNT_W-1:0]  err_prev_q;
   logic signed [COUNT_W-1:0]  target_last_q;
   logic signed [DRIVE_W-1:0]  drive_accum_q;
   logic [BRAKE_W-1:0]         brake_count_q;

   tick_word_type   tick_backlog[$];       // ticks waiting for the driver
   bridge_word_type bridge_words_due[$];   // predicted responses, oldest first

   int error_count  = 0;
   int req_idle_pct = 0;   // chance per word of a sender gap burst
   int rsp_idle_pct = 0;   // chance per cycle of a receiver stall burst
   int req_gap      = 0;
   int rsp_gap      = 0;
   int cruise_speed = 0;   // random-walk target for well-formed tick streams

   // -------------------------------------------------------------------------
   // clock and reset
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // one control tick of the speed loop; advances the mirrored state
   // -------------------------------------------------------------------------
   function automatic bridge_word_type pid_tick(tick_word_type t);
      logic signed [COUNT_W-1:0] speed;
      logic signed [COUNT_W-1:0] err;
      longint                    term;
      longint                    acc;
      longint                    lim;
      int                        brake_sum;
      bridge_word_type           w;
      // speed and error both wrap to 16 bits
      speed = t.encoder_count - SPEED_OFFSET;
      err   = t.target_speed - speed;
      // exact incremental term, then int16 saturation
      term = longint'(kp_q) * (longint'(err) - longint'(err_last_q))
           + longint'(ki_q) * longint'(err)
           + longint'(kd_q) * (longint'(err) - 2 * longint'(err_last_q)
                               + longint'(err_prev_q));
      if (term > 32767) begin
         term = 32767;
      end else if (term < -32768) begin
         term = -32768;
      end
      // symmetric clamp of the accumulator; a limit of zero pins it at zero
      acc = longint'(drive_accum_q) + term;
      lim = longint'(limit_q);
      if (acc > lim) begin
         acc = lim;
      end else if (acc < -lim) begin
         acc = -lim;
      end
      drive_accum_q = acc[DRIVE_W-1:0];
      // strict sign reversal of the target arms the brake (zero never counts)
      if ((t.target_speed > 0 && target_last_q < 0) ||
          (t.target_speed < 0 && target_last_q > 0)) begin
         brake_sum     = int'(brake_count_q) + int'(brake_ticks_q);
         brake_count_q = (brake_sum > int'(BRAKE_MAX)) ? BRAKE_MAX
                                                       : brake_sum[BRAKE_W-1:0];
      end
      if (brake_count_q != 0) begin
         brake_count_q = brake_count_q - 1'b1;
      end
      target_last_q = t.target_speed;
      err_prev_q    = err_last_q;
      err_last_q    = err;
      // bridge decode: brake wins, then forward for positive drive, else reverse
      w.drive_value = drive_accum_q;
      w.braking     = (brake_count_q != 0);
      if (w.braking) begin
         w.pin_a    = 1'b1;
         w.pin_b    = 1'b1;
         w.pwm_duty = '0;
      end else if (acc > 0) begin
         w.pin_a    = 1'b0;
         w.pin_b    = 1'b1;
         w.pwm_duty = DUTY_W'(acc);
      end else begin
         w.pin_a    = 1'b1;
         w.pin_b    = 1'b0;
         w.pwm_duty = DUTY_W'(-acc);
      end
      return w;
   endfunction

   // 4-state compare so an X on the port is caught
   task automatic check_field(string field, logic signed [31:0] expected_v,
                              logic signed [31:0] actual_v);
      if (expected_v !== actual_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d",
                  $time, field, expected_v, actual_v);
      end
   endtask

   // -------------------------------------------------------------------------
   // monitor: register shadow, prediction on request, check on response
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      tick_word_type   seen;
      bridge_word_type due;
      if (reset) begin
         kp_q          = GAIN_P_RESET;
         ki_q          = GAIN_I_RESET;
         kd_q          = GAIN_D_RESET;
         limit_q       = OUTPUT_LIMIT_RESET;
         brake_ticks_q = BRAKE_TICKS_RESET;
         err_last_q    = '0;
         err_prev_q    = '0;
         target_last_q = '0;
         drive_accum_q = '0;
         brake_count_q = '0;
      end else begin
         // register writes only land while the pipe is empty
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_index_type'(csr_chan.index))
               CSR_GAIN_P:       kp_q          = csr_chan.data;
               CSR_GAIN_I:       ki_q          = csr_chan.data;
               CSR_GAIN_D:       kd_q          = csr_chan.data;
               CSR_OUTPUT_LIMIT: limit_q       = csr_chan.data;
               CSR_BRAKE_TICKS:  brake_ticks_q = csr_chan.data[BTICK_W-1:0];
               default: ;
            endcase
         end
         // predict before popping so a same-edge response still finds its word
         if (req_chan.valid && req_chan.ready) begin
            seen.encoder_count = req_chan.encoder_count;
            seen.target_speed  = req_chan.target_speed;
            bridge_words_due.push_back(pid_tick(seen));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (bridge_words_due.size() == 0) begin
               error_count++;
               $display("%0t: response word with none pending, %s %0d",
                        $time, "expected none actual drive", rsp_chan.drive_value);
            end else begin
               due = bridge_words_due.pop_front();
               check_field("drive_value", due.drive_value, rsp_chan.drive_value);
               check_field("pin_a",       due.pin_a,       rsp_chan.pin_a);
               check_field("pin_b",       due.pin_b,       rsp_chan.pin_b);
               check_field("pwm_duty",    due.pwm_duty,    rsp_chan.pwm_duty);
               check_field("braking",     due.braking,     rsp_chan.braking);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // request driver: pulls ticks from the backlog, gaps come in bursts
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      tick_word_type next_tick;
      if (reset) begin
         req_chan.valid         <= 1'b0;
         req_chan.encoder_count <= '0;
         req_chan.target_speed  <= '0;
         req_gap = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         // previous word gone (or none): free to idle or present the next one
         if (req_gap > 0) begin
            req_gap--;
            req_chan.valid <= 1'b0;
         end else if (tick_backlog.size() != 0) begin
            next_tick = tick_backlog.pop_front();
            req_chan.valid         <= 1'b1;
            req_chan.encoder_count <= next_tick.encoder_count;
            req_chan.target_speed  <= next_tick.target_speed;
            if ($urandom_range(99) < req_idle_pct) begin
               req_gap = $urandom_range(1, 16);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response ready: stall bursts independent of valid
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap = 0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(99) < rsp_idle_pct) begin
            rsp_gap = $urandom_range(1, 16);
         end
      end
   end

   // -------------------------------------------------------------------------
   // watchdog: any handshake restarts the count
   // -------------------------------------------------------------------------
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL incremental_pid_motor_drive");
      $finish;
   end

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------
   task automatic add_tick(int enc, int tgt);
      tick_word_type t;
      t.encoder_count = COUNT_W'(enc);
      t.target_speed  = COUNT_W'(tgt);
      tick_backlog.push_back(t);
   endtask

   // one register write; valid drops for a cycle between writes
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic load_registers(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                                 logic [GAIN_W-1:0] kd, logic [LIMIT_W-1:0] lim,
                                 logic [BTICK_W-1:0] ticks);
      csr_write(CSR_GAIN_P, kp);
      csr_write(CSR_GAIN_I, ki);
      csr_write(CSR_GAIN_D, kd);
      csr_write(CSR_OUTPUT_LIMIT, lim);
      csr_write(CSR_BRAKE_TICKS, CSR_DATA_W'(ticks));
      @(negedge clock);
   endtask

   // every result produces one word, so empty queues mean the pipe is empty
   task automatic wait_until_idle();
      do @(negedge clock);
      while (tick_backlog.size() != 0 || req_chan.valid || bridge_words_due.size() != 0);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return GAIN_W'($urandom_range(1, 40));
         3:       return GAIN_W'($urandom_range(0, 1000));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return LIMIT_W'($urandom_range(1, 2000));
         default: return LIMIT_W'($urandom);
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 10;
         2:       return 30;
         default: return 60;
      endcase
   endfunction

   // mostly a tracking motor with a drifting target and the odd reversal;
   // the rest is raw noise across the full field range
   task automatic add_random_tick();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
         add_tick(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)));
      end else begin
         if (pick < 5) begin
            cruise_speed = (cruise_speed > 0) ? -int'($urandom_range(1, 3000))
                                              : int'($urandom_range(1, 3000));
         end else if (pick == 5) begin
            cruise_speed = 0;
         end else begin
            cruise_speed = cruise_speed + int'($urandom_range(0, 40)) - 20;
            if (cruise_speed > 30000 || cruise_speed < -30000) begin
               cruise_speed = 0;
            end
         end
         // encoder reads offset + actual speed, actual lags target a little
         add_tick(50 + cruise_speed + int'($urandom_range(0, 20)) - 10, cruise_speed);
      end
   endtask

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      int phase;
      int n;
      reset                  = 1'b1;
      csr_chan.valid         = 1'b0;
      csr_chan.index         = CSR_GAIN_P;
      csr_chan.data          = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults: rest, full forward to the clamp, hard reversal,
      // extremes of both fields
      req_idle_pct = 25;
      rsp_idle_pct = 25;
      add_tick(50, 0);             // zero error, zero drive -> reverse, duty 0
      add_tick(50, 32767);
      add_tick(50, 32767);
      add_tick(50, 32767);         // accumulator pinned at +limit
      add_tick(50, -32768);        // reversal arms the brake
      add_tick(50, -32768);
      add_tick(32767, -32768);
      add_tick(-32768, 32767);     // reversal again while still braking
      add_tick(-32768, 0);
      add_tick(0, -1);             // from zero target: no reversal
      wait_until_idle();

      // all gains at max, brake step above the nominal range: term saturates
      // both ways, alternating targets drive the brake counter to its ceiling
      load_registers('1, '1, '1, '1, '1);
      add_tick(50, 1);
      add_tick(50, -1);
      add_tick(50, 1);
      add_tick(50, -1);
      add_tick(50, 1);
      add_tick(50, -1);
      add_tick(32767, -32768);
      add_tick(-32768, 32767);
      wait_until_idle();

      // zero limit, zero brake step: drive stuck at zero, reversals ignored
      load_registers('1, '0, '0, '0, '0);
      add_tick(50, 1000);
      add_tick(50, -1000);
      add_tick(0, 0);
      wait_until_idle();

      // random phases; registers only move once the pipe has drained
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_registers(pick_gain(), pick_gain(), pick_gain(), pick_limit(),
                        BTICK_W'($urandom_range(0, 63)));
         if (phase == RANDOM_PHASES - 1) begin
            req_idle_pct = 0;   // closing stretch runs flat out
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = pick_idle_pct();
            rsp_idle_pct = pick_idle_pct();
         end
         for (n = 0; n < PHASE_TICKS; n++) begin
            add_random_tick();
         end
         wait_until_idle();
      end

      // drain margin: catch any stray word past the last expected one
      repeat (16) @(posedge clock);
      if (error_count == 0 && bridge_words_due.size() == 0) begin
         $display("PASS incremental_pid_motor_drive");
      end else begin
         $display("FAIL incremental_pid_motor_drive");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ipmd_pkg.sv
design/ipmd_if.sv
design/incremental_pid_motor_drive.sv
tb/sv/incremental_pid_motor_drive_tb.sv
